### src/c3mp_pkg.sv
package c3mp_pkg;

    // Defaults for the frame geometry and filter count
    localparam int DEF_IMG_ROWS    = 28;
    localparam int DEF_IMG_COLS    = 28;
    localparam int DEF_N_FILT      = 8;

    // Fixed datapath shape
    localparam int NF_MAX   = 8;
    localparam int TAPS     = 9;
    localparam int PIX_W    = 8;
    localparam int CIDX_W   = 7;
    localparam int COEF_W   = 16;
    localparam int X_W      = 9;
    localparam int PROD_W   = X_W + COEF_W;
    localparam int PART_W   = PROD_W + 2;
    localparam int SUM_W    = 28;
    localparam int POS_W    = 9;
    localparam int OPOS_W   = 4;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_COEF  = 1'b1;

    typedef logic [TAPS-1:0][PIX_W-1:0] t_win;
    typedef logic [NF_MAX-1:0][SUM_W-1:0] t_sums;

    // Position info travelling with a window
    typedef struct packed {
        logic              cc_odd;
        logic              cr_odd;
        logic [POS_W-1:0]  pr;
        logic [POS_W-1:0]  pc;
        logic              last;
    } t_meta;

    // One queue entry: a coefficient write or a classified window
    typedef struct packed {
        logic              is_coef;
        logic [CIDX_W-1:0] cidx;
        logic [COEF_W-1:0] cval;
        logic              conv;
        t_win              win;
        t_meta             meta;
    } t_qent;

    // Centre a pixel: 2p - 255 as a 9-bit signed value
    function automatic logic signed [X_W-1:0] centre(input logic [PIX_W-1:0] p);
        centre = {~p[PIX_W-1], p[PIX_W-2:0], 1'b1};
    endfunction

endpackage

### src/c3mp_front.sv
module c3mp_front #(
    parameter int IMG_ROWS = 28,
    parameter int IMG_COLS = 28
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic [c3mp_pkg::PIX_W-1:0]     i_pixel,
    input  logic [c3mp_pkg::CIDX_W-1:0]    i_cidx,
    input  logic [c3mp_pkg::COEF_W-1:0]    i_cval,
    input  logic                           i_qfull,
    output logic                           o_push,
    output c3mp_pkg::t_qent                o_ent
);
    import c3mp_pkg::*;

    localparam int RW = $clog2(IMG_ROWS);
    localparam int CW = $clog2(IMG_COLS);
    localparam int PR = (IMG_ROWS - 2) / 2;
    localparam int PC = (IMG_COLS - 2) / 2;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    t_win          r_win, n_win;
    logic [PIX_W-1:0] r_line0 [IMG_COLS];
    logic [PIX_W-1:0] r_line1 [IMG_COLS];
    logic [PIX_W-1:0] r_rd0, r_rd1;
    logic          pix_acc;
    logic [RW-1:0] cr;
    logic [CW-1:0] cc;
    logic [RW-1:0] pr;
    logic [CW-1:0] pc;
    logic          conv;

    assign o_ready = !i_qfull;
    assign o_push  = i_valid && !i_qfull;
    assign pix_acc = o_push && (i_cmd == CMD_PIXEL);

    // Raster position of the next pixel
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (pix_acc) begin
            if (r_col == CW'(IMG_COLS - 1)) begin
                n_col = '0;
                n_row = (r_row == RW'(IMG_ROWS - 1)) ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Line stores: read ahead at the next column, write at the current one
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_line0[r_col] <= r_rd1;
            r_line1[r_col] <= i_pixel;
        end
        r_rd0 <= r_line0[n_col];
        r_rd1 <= r_line1[n_col];
    end

    // Window shift with the new column on the right
    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]     = r_win[k*3 + 1];
            n_win[k*3 + 1] = r_win[k*3 + 2];
        end
        n_win[2] = r_rd0;
        n_win[5] = r_rd1;
        n_win[8] = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_win <= n_win;
        end
    end

    // Classify the conv position
    always_comb begin
        cr   = r_row - RW'(2);
        cc   = r_col - CW'(2);
        pr   = cr >> 1;
        pc   = cc >> 1;
        conv = (r_row >= RW'(2)) && (r_col >= CW'(2)) &&
               (pr < RW'(PR)) && (pc < CW'(PC));
    end

    always_comb begin
        o_ent          = '0;
        o_ent.is_coef  = (i_cmd == CMD_COEF);
        o_ent.cidx     = i_cidx;
        o_ent.cval     = i_cval;
        o_ent.conv     = conv;
        o_ent.win      = n_win;
        o_ent.meta.cc_odd = cc[0];
        o_ent.meta.cr_odd = cr[0];
        o_ent.meta.pr  = POS_W'(pr);
        o_ent.meta.pc  = POS_W'(pc);
        o_ent.meta.last = (pr == RW'(PR - 1)) && (pc == CW'(PC - 1));
    end

endmodule

### src/c3mp_queue.sv
module c3mp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  c3mp_pkg::t_qent  i_ent,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output c3mp_pkg::t_qent  o_ent
);
    import c3mp_pkg::*;

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_ent   = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

### src/c3mp_back.sv
module c3mp_back #(
    parameter int IMG_COLS    = 28,
    parameter int N_FILT      = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  c3mp_pkg::t_qent               i_ent,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [c3mp_pkg::OPOS_W-1:0]   o_row,
    output logic [c3mp_pkg::OPOS_W-1:0]   o_col,
    output c3mp_pkg::t_sums               o_pool,
    output logic                          o_last
);
    import c3mp_pkg::*;

    localparam int PC  = (IMG_COLS - 2) / 2;
    localparam int PCA = (PC > 1) ? $clog2(PC) : 1;

    logic                     adv;
    logic signed [COEF_W-1:0] r_coef [NF_MAX*TAPS];
    logic signed [PROD_W-1:0] r_prod [NF_MAX][TAPS];
    logic signed [PART_W-1:0] r_part [NF_MAX][3];
    t_sums                    r_sum;
    t_sums                    r_pend, n_pend;
    t_sums                    r_rowmem [PC];
    t_sums                    r_rowrd;
    t_sums                    row_wdata, n_pool;
    logic                     row_we;
    logic                     emit;
    logic                     r_v1, r_v2, r_v3;
    t_meta                    r_m1, r_m2, r_m3;
    logic                     r_ovalid;
    logic [OPOS_W-1:0]        r_orow, r_ocol;
    t_sums                    r_opool;
    logic                     r_olast;

    // Whole pipeline moves unless the output item is stalled
    assign adv   = !r_ovalid || i_ready;
    assign o_pop = adv && !i_empty;

    // Coefficient store, written in stream order
    always_ff @(posedge i_clk) begin
        if (o_pop && i_ent.is_coef && (i_ent.cidx < CIDX_W'(N_FILT * TAPS))) begin
            r_coef[i_ent.cidx] <= i_ent.cval;
        end
    end

    // Stage 1: one multiplier per filter tap
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int f = 0; f < NF_MAX; f++) begin
                for (int k = 0; k < TAPS; k++) begin
                    r_prod[f][k] <= centre(i_ent.win[k]) * r_coef[f*TAPS + k];
                end
            end
            r_m1 <= i_ent.meta;
        end
    end

    // Stage 2: sums of three taps
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int f = 0; f < NF_MAX; f++) begin
                for (int g = 0; g < 3; g++) begin
                    r_part[f][g] <= PART_W'(r_prod[f][g*3]) + PART_W'(r_prod[f][g*3 + 1])
                                  + PART_W'(r_prod[f][g*3 + 2]);
                end
            end
            r_m2 <= r_m1;
        end
    end

    // Stage 3: full sums and read of the upper-row partial maxima
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int f = 0; f < NF_MAX; f++) begin
                r_sum[f] <= SUM_W'(r_part[f][0]) + SUM_W'(r_part[f][1])
                          + SUM_W'(r_part[f][2]);
            end
            r_rowrd <= r_rowmem[PCA'(r_m2.pc)];
            r_m3    <= r_m2;
        end
    end

    // Valid bits of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop && !i_ent.is_coef && i_ent.conv;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Pooling: column pair, then row pair
    always_comb begin
        n_pend    = r_pend;
        row_wdata = r_sum;
        n_pool    = r_sum;
        row_we    = 1'b0;
        emit      = 1'b0;
        for (int f = 0; f < NF_MAX; f++) begin
            if ($signed(r_pend[f]) > $signed(r_sum[f])) begin
                row_wdata[f] = r_pend[f];
            end
            n_pool[f] = ($signed(r_rowrd[f]) > $signed(row_wdata[f])) ?
                        r_rowrd[f] : row_wdata[f];
            if (f >= N_FILT) begin
                n_pool[f] = '0;
            end
        end
        if (r_v3) begin
            if (!r_m3.cc_odd) begin
                n_pend = r_sum;
            end else if (!r_m3.cr_odd) begin
                row_we = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pend <= n_pend;
            if (row_we) begin
                r_rowmem[PCA'(r_m3.pc)] <= row_wdata;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_orow  <= OPOS_W'(r_m3.pr);
            r_ocol  <= OPOS_W'(r_m3.pc);
            r_opool <= n_pool;
            r_olast <= r_m3.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;
    assign o_pool  = r_opool;
    assign o_last  = r_olast;

`ifndef ASSERT_OFF
    a_out_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_ovalid)
        else $error("output valid after reset");
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_v1) && $stable(r_v2) && $stable(r_v3)))
        else $error("pipeline moved while stalled");
    a_last_at_end_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_ocol == OPOS_W'(PC - 1)))
        else $error("last flag off the final column");
`endif

endmodule

### src/conv3x3_maxpool2x2_forward_core.sv
// 3x3 valid convolution with eight filters followed by 2x2 max pooling.
// Input channel (s_axis): tuser = cmd. cmd 0 carries one pixel of a
// row-major frame; cmd 1 writes one Q4.12 coefficient at coef_index
// (filter*9 + row*3 + col). Coefficients must be loaded before use.
// Output channel (m_axis): one item per pooled position, carrying its
// row, column and the eight filter maxima at scale 510*4096; tlast marks
// the final position of the frame. Unused filters read as zero.
// Throughput: one input item per cycle while the queue is not full.
// A front stage holds the line stores and window and feeds a
// four-entry queue; the back stage runs 72 multipliers, a two-level
// adder tree and the pool compare. The pixel that completes a 2x2
// block passes through the queue, the back stages and the output register.
// Reset clears the raster position, queue and pipeline valid bits; the
// coefficient store is not cleared. When the receiver stalls the back
// pipeline holds, the queue fills and tready drops after four items.
module conv3x3_maxpool2x2_forward_core #(
    parameter int IMG_ROWS    = c3mp_pkg::DEF_IMG_ROWS,
    parameter int IMG_COLS    = c3mp_pkg::DEF_IMG_COLS,
    parameter int N_FILT      = c3mp_pkg::DEF_N_FILT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // pixel, coef_index, coef_value, pad
    input  logic         i_s_axis_tuser,   // cmd
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [231:0] o_m_axis_tdata,   // out_row, out_col, pool_0 .. pool_7
    output logic         o_m_axis_tlast    // last
);
    import c3mp_pkg::*;

    logic  qfull, qempty, push, pop;
    t_qent ent_in, ent_out;
    logic [OPOS_W-1:0] orow, ocol;
    t_sums opool;

    c3mp_front #(
        .IMG_ROWS (IMG_ROWS),
        .IMG_COLS (IMG_COLS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cmd   (i_s_axis_tuser),
        .i_pixel (i_s_axis_tdata[7:0]),
        .i_cidx  (i_s_axis_tdata[14:8]),
        .i_cval  (i_s_axis_tdata[30:15]),
        .i_qfull (qfull),
        .o_push  (push),
        .o_ent   (ent_in)
    );

    c3mp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (ent_in),
        .o_full  (qfull),
        .i_pop   (pop),
        .o_empty (qempty),
        .o_ent   (ent_out)
    );

    c3mp_back #(
        .IMG_COLS    (IMG_COLS),
        .N_FILT      (N_FILT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (qempty),
        .i_ent   (ent_out),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_row   (orow),
        .o_col   (ocol),
        .o_pool  (opool),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {opool, ocol, orow};

endmodule
